[rtl/dcaba_pkg.sv]
// Package for the dual-channel ADC block averager.
// Holds word types, field widths and the divider status type; no dependencies.
`timescale 1ns / 1ps

package dcaba_pkg;

    // Width of one converter sample and of a published average.
    localparam int SAMPLE_BITS = 10;

    // Default width of the per-channel sample counters.
    localparam int COUNT_BITS_DEF = 10;

    // Width and reset value of the window length register.
    localparam int             WIN_BITS  = 10;
    localparam logic [WIN_BITS-1:0] WIN_RESET = WIN_BITS'(67);

    // Input word: one timer tick.
    typedef struct packed {
        logic                   converter_idle;
        logic [SAMPLE_BITS-1:0] sample_value;
    } in_word_t;

    // Result word: one per tick.
    typedef struct packed {
        logic                   start_conversion;
        logic                   channel_select;
        logic [SAMPLE_BITS-1:0] average_first;
        logic [SAMPLE_BITS-1:0] average_second;
        logic                   updated_first;
        logic                   updated_second;
    } out_word_t;

    // Status of the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

[rtl/dcaba_divider.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Depends on dcaba_pkg for the status type.
`timescale 1ns / 1ps

module dcaba_divider
    import dcaba_pkg::*;
#(
    parameter int DIVIDEND_BITS = SAMPLE_BITS + COUNT_BITS_DEF,
    parameter int DIVISOR_BITS  = COUNT_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output div_status_t              status,
    output logic [DIVIDEND_BITS-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [DIVISOR_BITS-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_BITS-1:0] quo_reg, quo_next;
    logic [DIVISOR_BITS-1:0]  dvs_reg, dvs_next;

    logic [DIVISOR_BITS:0]    shifted;
    logic [DIVISOR_BITS+1:0]  diff;
    logic                     borrow;

    // Trial subtraction of the divisor from the shifted partial remainder.
    assign shifted = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign borrow  = diff[DIVISOR_BITS+1];

    // Next-state logic for one division step.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_BITS);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (borrow) begin
                rem_next = shifted[DIVISOR_BITS-1:0];
            end else begin
                rem_next = diff[DIVISOR_BITS-1:0];
            end
            quo_next = {quo_reg[DIVIDEND_BITS-2:0], ~borrow};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the datapath is not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

[rtl/dual_channel_adc_block_averager.sv]
// Top level of the dual-channel ADC block averager: tick sequencer and channel state.
// Depends on dcaba_pkg and dcaba_divider.
`timescale 1ns / 1ps

//  Channel   Direction  Ports                         Word
//  s_        in         s_valid, s_ready, s_data      in_word_t (idle flag, sample)
//  m_        out        m_valid, m_ready, m_data      out_word_t (start, select, averages)
//  cfg_      in         cfg_wr_en, cfg_wr_data        window length, no wait
//
//  A tick that publishes no average passes through ST_SERVE and ST_PUSH, with a
//  second ST_SERVE when the block moves on to the second channel in the same tick.
//  Publishing an average adds ST_DIV, in which the shared divider forms the
//  SAMPLE_BITS + COUNT_BITS quotient bits one at a time; when the first channel
//  publishes, the tick then goes back to ST_SERVE for the second channel.
//  Reset is synchronous and active low; s_ready rises in the first cycle after it.
//  A finished word waits in the output register, and the next word is accepted meanwhile.

module dual_channel_adc_block_averager
    import dcaba_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  in_word_t            s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output out_word_t           m_data,
    input  logic                cfg_wr_en,
    input  logic [WIN_BITS-1:0] cfg_wr_data
);

    localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SERVE,
        ST_DIV,
        ST_PUSH
    } state_t;

    state_t                 state_reg, state_next;
    logic [WIN_BITS-1:0]    window_reg;
    logic [1:0]             ready_reg, ready_next;
    logic                   active_reg, active_next;
    logic                   ch_reg, ch_next;
    logic [COUNT_BITS-1:0]  count_first_reg, count_first_next;
    logic [COUNT_BITS-1:0]  count_second_reg, count_second_next;
    logic [SUM_BITS-1:0]    sum_first_reg, sum_first_next;
    logic [SUM_BITS-1:0]    sum_second_reg, sum_second_next;
    logic [SAMPLE_BITS-1:0] avg_first_reg, avg_first_next;
    logic [SAMPLE_BITS-1:0] avg_second_reg, avg_second_next;
    logic                   idle_reg, idle_next;
    logic [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic                   start_reg, start_next;
    logic                   upd_first_reg, upd_first_next;
    logic                   upd_second_reg, upd_second_next;
    logic                   m_valid_reg, m_valid_next;
    out_word_t              m_data_reg, m_data_next;
    logic                   out_load;

    logic [WIN_BITS+COUNT_BITS-1:0] win_wide;
    logic [COUNT_BITS-1:0]          win_masked;
    logic [COUNT_BITS-1:0]          win_eff;
    logic [COUNT_BITS-1:0]          cur_count;
    logic [SUM_BITS-1:0]            cur_sum;
    logic [COUNT_BITS-1:0]          count_inc;
    logic [SUM_BITS-1:0]            sum_inc;

    logic                  div_start;
    div_status_t           div_status;
    logic [SUM_BITS-1:0]   div_quotient;

    // Window length taken to the counter width; a zero window counts as one.
    assign win_wide   = {{COUNT_BITS{1'b0}}, window_reg};
    assign win_masked = win_wide[COUNT_BITS-1:0];
    assign win_eff    = (win_masked == '0) ? COUNT_BITS'(1) : win_masked;

    // Sum and count of the channel being served, with the new sample added.
    assign cur_count = ch_reg ? count_second_reg : count_first_reg;
    assign cur_sum   = ch_reg ? sum_second_reg : sum_first_reg;
    assign count_inc = COUNT_BITS'(cur_count + 1'b1);
    assign sum_inc   = SUM_BITS'(cur_sum + SUM_BITS'(sample_reg));

    // Shared divider for publishing an average.
    dcaba_divider #(
        .DIVIDEND_BITS (SUM_BITS),
        .DIVISOR_BITS  (COUNT_BITS)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_inc),
        .divisor  (win_eff),
        .status   (div_status),
        .quotient (div_quotient)
    );

    // Tick sequencer: serve the active channel, divide when a window fills,
    // move on to the second channel when the first one collected a sample.
    always_comb begin
        state_next        = state_reg;
        ready_next        = ready_reg;
        active_next       = active_reg;
        ch_next           = ch_reg;
        count_first_next  = count_first_reg;
        count_second_next = count_second_reg;
        sum_first_next    = sum_first_reg;
        sum_second_next   = sum_second_reg;
        avg_first_next    = avg_first_reg;
        avg_second_next   = avg_second_reg;
        idle_next         = idle_reg;
        sample_next       = sample_reg;
        start_next        = start_reg;
        upd_first_next    = upd_first_reg;
        upd_second_next   = upd_second_reg;
        div_start         = 1'b0;
        out_load          = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    idle_next       = s_data.converter_idle;
                    sample_next     = s_data.sample_value;
                    ch_next         = active_reg;
                    start_next      = 1'b0;
                    upd_first_next  = 1'b0;
                    upd_second_next = 1'b0;
                    state_next      = ST_SERVE;
                end
            end
            ST_SERVE: begin
                if (ready_reg[ch_reg]) begin
                    // No conversion pending: request one, busy for the rest of the tick.
                    ready_next[ch_reg] = 1'b0;
                    start_next         = 1'b1;
                    state_next         = ST_PUSH;
                end else if (!idle_reg) begin
                    state_next = ST_PUSH;
                end else begin
                    ready_next[ch_reg] = 1'b1;
                    if (count_inc >= win_eff) begin
                        // Window full: divide the new sum, then clear the channel.
                        div_start = 1'b1;
                        if (ch_reg) begin
                            sum_second_next   = '0;
                            count_second_next = '0;
                        end else begin
                            sum_first_next   = '0;
                            count_first_next = '0;
                        end
                        state_next = ST_DIV;
                    end else begin
                        if (ch_reg) begin
                            sum_second_next   = sum_inc;
                            count_second_next = count_inc;
                        end else begin
                            sum_first_next   = sum_inc;
                            count_first_next = count_inc;
                        end
                        active_next = ~ch_reg;
                        if (!ch_reg) begin
                            ch_next    = 1'b1;
                            state_next = ST_SERVE;
                        end else begin
                            state_next = ST_PUSH;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    if (ch_reg) begin
                        avg_second_next = div_quotient[SAMPLE_BITS-1:0];
                        upd_second_next = 1'b1;
                    end else begin
                        avg_first_next = div_quotient[SAMPLE_BITS-1:0];
                        upd_first_next = 1'b1;
                    end
                    active_next = ~ch_reg;
                    if (!ch_reg) begin
                        ch_next    = 1'b1;
                        state_next = ST_SERVE;
                    end else begin
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_PUSH: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The divider reads the sum before the serve step clears it; the sum
    // must therefore include the new sample at that point.
    // Output word, assembled from the settled channel state.
    always_comb begin
        m_data_next                  = m_data_reg;
        m_valid_next                 = m_valid_reg;
        if (out_load) begin
            m_data_next.start_conversion = start_reg;
            m_data_next.channel_select   = active_reg;
            m_data_next.average_first    = avg_first_reg;
            m_data_next.average_second   = avg_second_reg;
            m_data_next.updated_first    = upd_first_reg;
            m_data_next.updated_second   = upd_second_reg;
            m_valid_next                 = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // State, channel registers and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            window_reg       <= WIN_RESET;
            ready_reg        <= 2'b11;
            active_reg       <= 1'b0;
            ch_reg           <= 1'b0;
            count_first_reg  <= '0;
            count_second_reg <= '0;
            sum_first_reg    <= '0;
            sum_second_reg   <= '0;
            avg_first_reg    <= '0;
            avg_second_reg   <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            if (cfg_wr_en) begin
                window_reg <= cfg_wr_data;
            end
            ready_reg        <= ready_next;
            active_reg       <= active_next;
            ch_reg           <= ch_next;
            count_first_reg  <= count_first_next;
            count_second_reg <= count_second_next;
            sum_first_reg    <= sum_first_next;
            sum_second_reg   <= sum_second_next;
            avg_first_reg    <= avg_first_next;
            avg_second_reg   <= avg_second_next;
            m_valid_reg      <= m_valid_next;
        end
        idle_reg       <= idle_next;
        sample_reg     <= sample_next;
        start_reg      <= start_next;
        upd_first_reg  <= upd_first_next;
        upd_second_reg <= upd_second_next;
        m_data_reg     <= m_data_next;
    end

    assign s_ready = aresetn && (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // An accepted word keeps the input closed in the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted again right after a word was taken");

    // The divider only runs while a tick is being worked on.
    a_div_inside_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.busy |-> (state_reg == ST_DIV))
        else $error("divider busy outside the divide step");

    // The divider is never restarted while a division is in progress.
    a_div_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_status.busy)
        else $error("divider started while busy");

    // A finished word never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("output word overwritten before it was taken");

endmodule
